/* src/dhlm_pkg.sv */
// Shared types, widths and constant tables of the DH link matrix block.
// No dependencies; every other file in src takes its names from here by scope.
package dhlm_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int TABLE_LEN = 24;
	localparam int SH_W = $clog2(TABLE_LEN);

	localparam int ANG_W = 17;
	localparam int LEN_W = 24;
	localparam int TRIG_W = 16;
	localparam int WRAP_W = 16;
	localparam int PH_W = 32;
	localparam int CW = 34;
	localparam int ZW = 33;

	localparam int TURN_UNITS = 46080;
	localparam int FRAC_DIV = 45;
	localparam int FRAC_BIAS = (TURN_UNITS / 2) / 1024;
	localparam int RECIP_45 = 93207;
	localparam int RECIP_SH = 22;
	localparam int QA_W = 10;
	localparam int RA_W = $clog2(FRAC_DIV);
	localparam int FRAC_W = PH_W - QA_W;

	localparam int CORDIC_GAIN_Q30 = 652032874;
	localparam int Q14_ONE = 16384;

	localparam logic signed [ZW-1:0] Z_QUARTER = ZW'(64'h4000_0000);
	localparam logic signed [ZW-1:0] Z_HALF = ZW'(64'h8000_0000);

	localparam logic [31:0] ATAN_PHASE [TABLE_LEN] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215,
		2608, 1304, 652, 326, 163, 81
	};

	typedef logic [FRAC_W-1:0] frac_tbl_t [FRAC_DIV];

	// Phase of the part of an angle that is left over after whole steps of 45 units.
	function automatic frac_tbl_t build_frac_phase();
		frac_tbl_t t;
		for (int k = 0; k < FRAC_DIV; k++) begin
			t[k] = FRAC_W'(((64'(k) << FRAC_W) + 64'(FRAC_BIAS)) / FRAC_DIV);
		end
		return t;
	endfunction

	localparam frac_tbl_t FRAC_PHASE = build_frac_phase();

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
	} rot_t;

	typedef struct packed {
		rot_t th;
		rot_t al;
		logic flip_th;
		logic flip_al;
		logic signed [LEN_W-1:0] offset;
		logic signed [LEN_W-1:0] length;
	} stage_t;

	typedef struct packed {
		logic signed [TRIG_W-1:0] cos_theta;
		logic signed [TRIG_W-1:0] sin_theta;
		logic signed [TRIG_W-1:0] neg_st_ca;
		logic signed [TRIG_W-1:0] ct_ca;
		logic signed [TRIG_W-1:0] sin_alpha;
		logic signed [TRIG_W-1:0] st_sa;
		logic signed [TRIG_W-1:0] neg_ct_sa;
		logic signed [TRIG_W-1:0] cos_alpha;
		logic signed [LEN_W-1:0] trans_x;
		logic signed [LEN_W-1:0] trans_y;
		logic signed [LEN_W-1:0] trans_z;
	} res_t;

endpackage

/* src/dhlm_if.sv */
// Handshake interfaces for the link word going in and the matrix word coming out.
// Depends on dhlm_pkg for field widths.
interface dhlm_in_if;
	logic valid;
	logic ready;
	logic signed [dhlm_pkg::ANG_W-1:0] joint_angle;
	logic signed [dhlm_pkg::ANG_W-1:0] twist_angle;
	logic signed [dhlm_pkg::LEN_W-1:0] link_offset;
	logic signed [dhlm_pkg::LEN_W-1:0] link_length;

	modport source (output valid, joint_angle, twist_angle, link_offset, link_length,
		input ready);
	modport sink (input valid, joint_angle, twist_angle, link_offset, link_length,
		output ready);
endinterface

interface dhlm_out_if;
	logic valid;
	logic ready;
	logic signed [dhlm_pkg::TRIG_W-1:0] cos_theta;
	logic signed [dhlm_pkg::TRIG_W-1:0] sin_theta;
	logic signed [dhlm_pkg::TRIG_W-1:0] neg_st_ca;
	logic signed [dhlm_pkg::TRIG_W-1:0] ct_ca;
	logic signed [dhlm_pkg::TRIG_W-1:0] sin_alpha;
	logic signed [dhlm_pkg::TRIG_W-1:0] st_sa;
	logic signed [dhlm_pkg::TRIG_W-1:0] neg_ct_sa;
	logic signed [dhlm_pkg::TRIG_W-1:0] cos_alpha;
	logic signed [dhlm_pkg::LEN_W-1:0] trans_x;
	logic signed [dhlm_pkg::LEN_W-1:0] trans_y;
	logic signed [dhlm_pkg::LEN_W-1:0] trans_z;

	modport source (output valid, cos_theta, sin_theta, neg_st_ca, ct_ca, sin_alpha,
		st_sa, neg_ct_sa, cos_alpha, trans_x, trans_y, trans_z, input ready);
	modport sink (input valid, cos_theta, sin_theta, neg_st_ca, ct_ca, sin_alpha,
		st_sa, neg_ct_sa, cos_alpha, trans_x, trans_y, trans_z, output ready);
endinterface

/* src/dh_link_matrix_core.sv */
// Top level of the DH link matrix block: front end, chain of CORDIC cells, back end.
// Depends on dhlm_pkg, dhlm_if, dhlm_front, dhlm_cell and dhlm_back.
//
// Each link word (theta, alpha in 1/128 degree, offset h and length r in Q16.8) gives
// one matrix word with the eleven non-constant entries of the DH transform: rotation
// terms in Q2.14, translation r*cos, r*sin and h in Q16.8. Any 17-bit angle is wrapped
// to one turn. The block takes one word per clock; each word passes through angle
// preparation, the chain of CORDIC cells and then rounding, multiplication and
// saturation. The whole pipeline moves together; it halts only while a finished
// word waits at the output and the sink is not ready.
module dh_link_matrix_core (
	input logic clk,
	input logic arst_n,
	dhlm_in_if.sink item,
	dhlm_out_if.source matrix
);

	localparam int N = dhlm_pkg::CORDIC_STAGES;

	logic adv;
	logic chain_v [N+1];
	dhlm_pkg::stage_t chain [N+1];
	logic res_valid;
	dhlm_pkg::res_t res;

	assign adv = !res_valid || matrix.ready;
	assign item.ready = adv;

	dhlm_front u_front (
		.clk (clk),
		.arst_n (arst_n),
		.adv (adv),
		.up_valid (item.valid),
		.joint_angle (item.joint_angle),
		.twist_angle (item.twist_angle),
		.link_offset (item.link_offset),
		.link_length (item.link_length),
		.dn_valid (chain_v[0]),
		.dn (chain[0])
	);

	for (genvar i = 0; i < N; i++) begin : g_cell
		dhlm_cell u_cell (
			.clk (clk),
			.arst_n (arst_n),
			.adv (adv),
			.shift (dhlm_pkg::SH_W'(i)),
			.up_valid (chain_v[i]),
			.up (chain[i]),
			.dn_valid (chain_v[i+1]),
			.dn (chain[i+1])
		);
	end

	dhlm_back u_back (
		.clk (clk),
		.arst_n (arst_n),
		.adv (adv),
		.up_valid (chain_v[N]),
		.up (chain[N]),
		.dn_valid (res_valid),
		.dn (res)
	);

	assign matrix.valid = res_valid;
	assign matrix.cos_theta = res.cos_theta;
	assign matrix.sin_theta = res.sin_theta;
	assign matrix.neg_st_ca = res.neg_st_ca;
	assign matrix.ct_ca = res.ct_ca;
	assign matrix.sin_alpha = res.sin_alpha;
	assign matrix.st_sa = res.st_sa;
	assign matrix.neg_ct_sa = res.neg_ct_sa;
	assign matrix.cos_alpha = res.cos_alpha;
	assign matrix.trans_x = res.trans_x;
	assign matrix.trans_y = res.trans_y;
	assign matrix.trans_z = res.trans_z;

endmodule

/* src/dhlm_front.sv */
// Angle preparation: wraps both angles to one turn, scales them to a 32-bit phase
// and folds the phase into the right half-plane. Depends on dhlm_pkg.
module dhlm_front (
	input logic clk,
	input logic arst_n,
	input logic adv,
	input logic up_valid,
	input logic signed [dhlm_pkg::ANG_W-1:0] joint_angle,
	input logic signed [dhlm_pkg::ANG_W-1:0] twist_angle,
	input logic signed [dhlm_pkg::LEN_W-1:0] link_offset,
	input logic signed [dhlm_pkg::LEN_W-1:0] link_length,
	output logic dn_valid,
	output dhlm_pkg::stage_t dn
);

	localparam int AW = dhlm_pkg::ANG_W + 1;
	localparam int PW = dhlm_pkg::WRAP_W + dhlm_pkg::ANG_W;
	localparam logic signed [AW-1:0] TURN = AW'(dhlm_pkg::TURN_UNITS);
	localparam logic signed [AW-1:0] TURN2 = AW'(2 * dhlm_pkg::TURN_UNITS);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [1:0][dhlm_pkg::ANG_W-1:0] ang_s1;
	logic [1:0][dhlm_pkg::WRAP_W-1:0] wrap_d, wrap_s2, wrap_s3;
	logic [1:0][dhlm_pkg::QA_W-1:0] qa_d, qa_s3, qa_s4;
	logic [1:0][dhlm_pkg::RA_W-1:0] ra_d, ra_s4;
	logic [1:0][dhlm_pkg::ZW-1:0] z_d;
	logic [1:0] flip_d;
	logic signed [dhlm_pkg::LEN_W-1:0] h_s1, h_s2, h_s3, h_s4;
	logic signed [dhlm_pkg::LEN_W-1:0] r_s1, r_s2, r_s3, r_s4;
	dhlm_pkg::stage_t data_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= up_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Wrap modulo one turn; the 17-bit input spans less than three turns.
	always_comb begin
		logic signed [AW-1:0] a, w;
		for (int k = 0; k < 2; k++) begin
			a = AW'(signed'(ang_s1[k]));
			if (a >= TURN) begin
				w = a - TURN;
			end else if (a >= 0) begin
				w = a;
			end else if (a >= -TURN) begin
				w = a + TURN;
			end else begin
				w = a + TURN2;
			end
			wrap_d[k] = w[dhlm_pkg::WRAP_W-1:0];
		end
	end

	// Whole steps of 45 units by reciprocal multiplication; exact over one turn.
	always_comb begin
		logic [PW-1:0] prod;
		for (int k = 0; k < 2; k++) begin
			prod = PW'(wrap_s2[k]) * PW'(dhlm_pkg::RECIP_45);
			qa_d[k] = prod[dhlm_pkg::RECIP_SH +: dhlm_pkg::QA_W];
		end
	end

	always_comb begin
		logic [dhlm_pkg::WRAP_W-1:0] rem;
		for (int k = 0; k < 2; k++) begin
			rem = wrap_s3[k] - (dhlm_pkg::WRAP_W'(qa_s3[k]) *
				dhlm_pkg::WRAP_W'(dhlm_pkg::FRAC_DIV));
			ra_d[k] = rem[dhlm_pkg::RA_W-1:0];
		end
	end

	// Phase is whole steps times 2^22 plus the rounded phase of the remainder.
	// A phase beyond a quarter turn is brought back by half a turn and flipped.
	always_comb begin
		logic [dhlm_pkg::FRAC_W-1:0] frac;
		logic [dhlm_pkg::PH_W-1:0] ph;
		logic signed [dhlm_pkg::ZW-1:0] zs;
		for (int k = 0; k < 2; k++) begin
			frac = (ra_s4[k] < dhlm_pkg::RA_W'(dhlm_pkg::FRAC_DIV)) ?
				dhlm_pkg::FRAC_PHASE[ra_s4[k]] : '0;
			ph = {qa_s4[k], frac};
			zs = dhlm_pkg::ZW'(signed'(ph));
			if (zs > dhlm_pkg::Z_QUARTER) begin
				z_d[k] = zs - dhlm_pkg::Z_HALF;
				flip_d[k] = 1'b1;
			end else if (zs < -dhlm_pkg::Z_QUARTER) begin
				z_d[k] = zs + dhlm_pkg::Z_HALF;
				flip_d[k] = 1'b1;
			end else begin
				z_d[k] = zs;
				flip_d[k] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ang_s1[0] <= joint_angle;
			ang_s1[1] <= twist_angle;
			h_s1 <= link_offset;
			r_s1 <= link_length;
			wrap_s2 <= wrap_d;
			h_s2 <= h_s1;
			r_s2 <= r_s1;
			wrap_s3 <= wrap_s2;
			qa_s3 <= qa_d;
			h_s3 <= h_s2;
			r_s3 <= r_s2;
			qa_s4 <= qa_s3;
			ra_s4 <= ra_d;
			h_s4 <= h_s3;
			r_s4 <= r_s3;
			data_s5.th.x <= dhlm_pkg::CW'(dhlm_pkg::CORDIC_GAIN_Q30);
			data_s5.th.y <= '0;
			data_s5.th.z <= z_d[0];
			data_s5.al.x <= dhlm_pkg::CW'(dhlm_pkg::CORDIC_GAIN_Q30);
			data_s5.al.y <= '0;
			data_s5.al.z <= z_d[1];
			data_s5.flip_th <= flip_d[0];
			data_s5.flip_al <= flip_d[1];
			data_s5.offset <= h_s4;
			data_s5.length <= r_s4;
		end
	end

	assign dn_valid = v_s5;
	assign dn = data_s5;

`ifndef SYNTHESIS
	a_wrap_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (wrap_s2[0] < dhlm_pkg::WRAP_W'(dhlm_pkg::TURN_UNITS)) &&
			(wrap_s2[1] < dhlm_pkg::WRAP_W'(dhlm_pkg::TURN_UNITS)))
		else $error("wrapped angle outside one turn");
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> (ra_s4[0] < dhlm_pkg::RA_W'(dhlm_pkg::FRAC_DIV)) &&
			(ra_s4[1] < dhlm_pkg::RA_W'(dhlm_pkg::FRAC_DIV)))
		else $error("remainder of step division out of range");
	a_fold_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |-> (data_s5.th.z <= dhlm_pkg::Z_QUARTER) &&
			(data_s5.th.z >= -dhlm_pkg::Z_QUARTER) &&
			(data_s5.al.z <= dhlm_pkg::Z_QUARTER) &&
			(data_s5.al.z >= -dhlm_pkg::Z_QUARTER))
		else $error("folded phase beyond a quarter turn");
`endif

endmodule

/* src/dhlm_cell.sv */
// One CORDIC rotation step for both angles, registered, with the link word alongside.
// Depends on dhlm_pkg for the stage type and the arctangent table.
module dhlm_cell (
	input logic clk,
	input logic arst_n,
	input logic adv,
	input logic [dhlm_pkg::SH_W-1:0] shift,
	input logic up_valid,
	input dhlm_pkg::stage_t up,
	output logic dn_valid,
	output dhlm_pkg::stage_t dn
);

	logic valid_s1;
	dhlm_pkg::stage_t data_s1;
	dhlm_pkg::stage_t next_d;

	function automatic dhlm_pkg::rot_t rotate(input dhlm_pkg::rot_t r,
		input logic [dhlm_pkg::SH_W-1:0] sh);
		dhlm_pkg::rot_t o;
		logic signed [dhlm_pkg::CW-1:0] xs, ys;
		logic signed [dhlm_pkg::ZW-1:0] at;
		xs = r.x >>> sh;
		ys = r.y >>> sh;
		at = dhlm_pkg::ZW'(dhlm_pkg::ATAN_PHASE[sh]);
		if (r.z >= 0) begin
			o.x = r.x - ys;
			o.y = r.y + xs;
			o.z = r.z - at;
		end else begin
			o.x = r.x + ys;
			o.y = r.y - xs;
			o.z = r.z + at;
		end
		return o;
	endfunction

	always_comb begin
		next_d = up;
		next_d.th = rotate(up.th, shift);
		next_d.al = rotate(up.al, shift);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_s1 <= next_d;
		end
	end

	assign dn_valid = valid_s1;
	assign dn = data_s1;

endmodule

/* src/dhlm_back.sv */
// Rounds the CORDIC results to Q2.14, forms the matrix products and the translation,
// and holds the finished matrix word. Depends on dhlm_pkg.
module dhlm_back (
	input logic clk,
	input logic arst_n,
	input logic adv,
	input logic up_valid,
	input dhlm_pkg::stage_t up,
	output logic dn_valid,
	output dhlm_pkg::res_t dn
);

	localparam int TW = dhlm_pkg::TRIG_W;
	localparam int LW = dhlm_pkg::LEN_W;
	localparam int CW = dhlm_pkg::CW;
	localparam int PQ = 2 * TW;
	localparam int PL = LW + TW;
	localparam logic signed [CW-1:0] TRIG_RND = CW'(32768);
	localparam logic signed [CW-1:0] TRIG_MAX = CW'(dhlm_pkg::Q14_ONE);
	localparam logic signed [PQ-1:0] Q_RND = PQ'(8192);
	localparam logic signed [PL-1:0] L_RND = PL'(8192);
	localparam logic signed [PL-1:0] L_MAX = PL'(8388607);
	localparam logic signed [PL-1:0] L_MIN = -PL'(8388608);

	logic valid_s1, valid_s2, valid_s3;
	logic signed [TW-1:0] ct_s1, st_s1, ca_s1, sa_s1;
	logic signed [TW-1:0] ct_s2, st_s2, ca_s2, sa_s2;
	logic signed [LW-1:0] h_s1, r_s1, h_s2;
	logic signed [PQ-1:0] stca_s2, ctca_s2, stsa_s2, ctsa_s2;
	logic signed [PL-1:0] tx_s2, ty_s2;
	dhlm_pkg::res_t res_s3;

	function automatic logic signed [TW-1:0] to_q14(input logic signed [CW-1:0] v,
		input logic flip);
		logic signed [CW-1:0] n, t;
		n = flip ? -v : v;
		t = (n + TRIG_RND) >>> 16;
		if (t > TRIG_MAX) begin
			return TW'(TRIG_MAX);
		end else if (t < -TRIG_MAX) begin
			return TW'(-TRIG_MAX);
		end
		return t[TW-1:0];
	endfunction

	function automatic logic signed [TW-1:0] round_q(input logic signed [PQ-1:0] p);
		logic signed [PQ-1:0] t;
		t = (p + Q_RND) >>> 14;
		return t[TW-1:0];
	endfunction

	// Only the most negative length against a trig value of minus one saturates.
	function automatic logic signed [LW-1:0] round_len(input logic signed [PL-1:0] p);
		logic signed [PL-1:0] t;
		t = (p + L_RND) >>> 14;
		if (t > L_MAX) begin
			return LW'(L_MAX);
		end else if (t < L_MIN) begin
			return LW'(L_MIN);
		end
		return t[LW-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= up_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ct_s1 <= to_q14(up.th.x, up.flip_th);
			st_s1 <= to_q14(up.th.y, up.flip_th);
			ca_s1 <= to_q14(up.al.x, up.flip_al);
			sa_s1 <= to_q14(up.al.y, up.flip_al);
			h_s1 <= up.offset;
			r_s1 <= up.length;

			stca_s2 <= PQ'(st_s1) * PQ'(ca_s1);
			ctca_s2 <= PQ'(ct_s1) * PQ'(ca_s1);
			stsa_s2 <= PQ'(st_s1) * PQ'(sa_s1);
			ctsa_s2 <= PQ'(ct_s1) * PQ'(sa_s1);
			tx_s2 <= PL'(r_s1) * PL'(ct_s1);
			ty_s2 <= PL'(r_s1) * PL'(st_s1);
			ct_s2 <= ct_s1;
			st_s2 <= st_s1;
			ca_s2 <= ca_s1;
			sa_s2 <= sa_s1;
			h_s2 <= h_s1;

			res_s3.cos_theta <= ct_s2;
			res_s3.sin_theta <= st_s2;
			res_s3.neg_st_ca <= -round_q(stca_s2);
			res_s3.ct_ca <= round_q(ctca_s2);
			res_s3.sin_alpha <= sa_s2;
			res_s3.st_sa <= round_q(stsa_s2);
			res_s3.neg_ct_sa <= -round_q(ctsa_s2);
			res_s3.cos_alpha <= ca_s2;
			res_s3.trans_x <= round_len(tx_s2);
			res_s3.trans_y <= round_len(ty_s2);
			res_s3.trans_z <= h_s2;
		end
	end

	assign dn_valid = valid_s3;
	assign dn = res_s3;

`ifndef SYNTHESIS
	a_trig_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (ct_s1 <= TW'(TRIG_MAX)) && (ct_s1 >= -TW'(TRIG_MAX)) &&
			(st_s1 <= TW'(TRIG_MAX)) && (st_s1 >= -TW'(TRIG_MAX)) &&
			(ca_s1 <= TW'(TRIG_MAX)) && (ca_s1 >= -TW'(TRIG_MAX)) &&
			(sa_s1 <= TW'(TRIG_MAX)) && (sa_s1 >= -TW'(TRIG_MAX)))
		else $error("rounded trig value beyond one");
	a_unit_circle: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (PQ'(ct_s2) * PQ'(ct_s2) + PQ'(st_s2) * PQ'(st_s2)) >
			PQ'(32'sd260000000))
		else $error("cos and sin of theta far off the unit circle");
	a_prod_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> (res_s3.ct_ca <= TW'(TRIG_MAX)) && (res_s3.ct_ca >= -TW'(TRIG_MAX)) &&
			(res_s3.st_sa <= TW'(TRIG_MAX)) && (res_s3.st_sa >= -TW'(TRIG_MAX)))
		else $error("rotation product beyond one");
`endif

endmodule
